// ===== rtl/e2q_pkg.sv =====
`default_nettype none
package e2q_pkg;

	// Fixed-point formats used inside the datapath. Magnitudes are unsigned Q30
	// with a top value of exactly one; squares of the half angle need 32 bits.
	localparam int Q_FRAC = 30;
	typedef logic [Q_FRAC:0] mag_t;
	typedef logic [31:0]     sq_t;

	localparam mag_t        Q30_ONE = mag_t'(1) << Q_FRAC;
	localparam logic [31:0] PI_Q30  = 32'd3373259426;

	// Taylor series of the half-angle sine and cosine, evaluated by Horner steps.
	localparam int HORNER_STEPS = 5;
	localparam int unsigned SIN_DIV [HORNER_STEPS] = '{110, 72, 42, 20, 6};
	localparam int unsigned COS_DIV [HORNER_STEPS] = '{132, 90, 56, 30, 12};

	// Pipeline depths.
	localparam int STEP_LAT = 2;
	localparam int TRIG_LAT = 4 + STEP_LAT * HORNER_STEPS;
	localparam int COMB_LAT = 5;

	// Sine magnitude, cosine and sign of one half angle.
	typedef struct packed {
		logic neg;
		mag_t s;
		mag_t c;
	} half_trig_t;

	// Operands that travel down the Horner chain.
	typedef struct packed {
		logic neg;
		mag_t xm;
		sq_t  x2;
		mag_t ts;
		mag_t tc;
	} horner_t;

endpackage
`default_nettype wire

// ===== rtl/e2q_if.sv =====
`default_nettype none
interface e2q_angle_if #(parameter int ANGLE_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] roll_angle;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] yaw_angle;

	modport source(output valid, output roll_angle, output pitch_angle,
		output yaw_angle, input ready);
	modport sink(input valid, input roll_angle, input pitch_angle,
		input yaw_angle, output ready);
endinterface

interface e2q_quat_if #(parameter int OUT_W = 16);
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] quat_w;
	logic signed [OUT_W-1:0] quat_x;
	logic signed [OUT_W-1:0] quat_y;
	logic signed [OUT_W-1:0] quat_z;

	modport source(output valid, output quat_w, output quat_x, output quat_y,
		output quat_z, input ready);
	modport sink(input valid, input quat_w, input quat_x, input quat_y,
		input quat_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/e2q_horner_stage.sv =====
`default_nettype none
module e2q_horner_stage #(
	parameter int unsigned KS = 6,
	parameter int unsigned KC = 12
) (
	input  logic             clk,
	input  logic             en,
	input  e2q_pkg::horner_t din,
	output e2q_pkg::horner_t dout
);
	import e2q_pkg::*;

	// Exact floor division of a 32-bit value by a constant: multiply by the
	// rounded-up reciprocal and shift.
	localparam int          LS  = $clog2(KS);
	localparam int          LC  = $clog2(KC);
	localparam int          SHS = 32 + LS;
	localparam int          SHC = 32 + LC;
	localparam logic [32:0] MS  = 33'(((65'd1 << SHS) + 65'(KS) - 65'd1) / 65'(KS));
	localparam logic [32:0] MC  = 33'(((65'd1 << SHC) + 65'(KC) - 65'd1) / 65'(KC));

	logic [62:0] ps_prod, pc_prod;
	logic [64:0] qs_prod, qc_prod;

	sq_t  x2_s1, ns_s1, nc_s1;
	mag_t xm_s1;
	logic neg_s1;
	horner_t dout_s2;

	// Registered product x2 * t in Q30. The product stays below 2^32 because t is at most one.
	assign ps_prod = 63'(din.x2) * 63'(din.ts);
	assign pc_prod = 63'(din.x2) * 63'(din.tc);

	always_ff @(posedge clk) begin
		if (en) begin
			ns_s1  <= ps_prod[61:30];
			nc_s1  <= pc_prod[61:30];
			x2_s1  <= din.x2;
			xm_s1  <= din.xm;
			neg_s1 <= din.neg;
		end
	end

	// Behind that register: divide by the series constant and subtract from one.
	assign qs_prod = 65'(ns_s1) * 65'(MS);
	assign qc_prod = 65'(nc_s1) * 65'(MC);

	always_ff @(posedge clk) begin
		if (en) begin
			dout_s2.ts  <= Q30_ONE - mag_t'(qs_prod >> SHS);
			dout_s2.tc  <= Q30_ONE - mag_t'(qc_prod >> SHC);
			dout_s2.x2  <= x2_s1;
			dout_s2.xm  <= xm_s1;
			dout_s2.neg <= neg_s1;
		end
	end

	assign dout = dout_s2;

endmodule
`default_nettype wire

// ===== rtl/e2q_trig.sv =====
`default_nettype none
module e2q_trig #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [ANGLE_BITS-1:0]  angle,
	output e2q_pkg::half_trig_t    trig
);
	import e2q_pkg::*;

	logic [31:0] phase;
	logic [63:0] xm_prod;
	logic [61:0] x2_prod;
	logic [61:0] sin_prod;
	logic [62:0] cos_prod;
	logic [31:0] sin_raw;
	logic [31:0] cos_half;

	logic [31:0] u_s1;
	logic        neg_s1;
	mag_t        xm_s2;
	logic        neg_s2;
	sq_t         x2_s3;
	mag_t        xm_s3;
	logic        neg_s3;
	half_trig_t  trig_s14;

	horner_t chain [HORNER_STEPS+1];

	// The angle is left-aligned to a 32-bit phase, so its half angle spans
	// [-pi/2, pi/2). The magnitude and the sign are carried apart.
	assign phase = 32'(angle) << (32 - ANGLE_BITS);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= phase[31];
			u_s1   <= phase[31] ? (~phase + 32'd1) : phase;
		end
	end

	// Half-angle magnitude in radians, Q30, rounded.
	assign xm_prod = 64'(u_s1) * 64'(PI_Q30) + (64'd1 << 31);

	always_ff @(posedge clk) begin
		if (en) begin
			xm_s2  <= xm_prod[62:32];
			neg_s2 <= neg_s1;
		end
	end

	assign x2_prod = 62'(xm_s2) * 62'(xm_s2) + (62'd1 << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s3  <= x2_prod[61:30];
			xm_s3  <= xm_s2;
			neg_s3 <= neg_s2;
		end
	end

	assign chain[0] = '{neg: neg_s3, xm: xm_s3, x2: x2_s3, ts: Q30_ONE, tc: Q30_ONE};

	for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_step
		e2q_horner_stage #(
			.KS(SIN_DIV[g]),
			.KC(COS_DIV[g])
		) u_stage (
			.clk (clk),
			.en  (en),
			.din (chain[g]),
			.dout(chain[g+1])
		);
	end

	// Closing products of both series, with the clamps.
	assign sin_prod = 62'(chain[HORNER_STEPS].xm) * 62'(chain[HORNER_STEPS].ts);
	assign cos_prod = 63'(chain[HORNER_STEPS].x2) * 63'(chain[HORNER_STEPS].tc);
	assign sin_raw  = sin_prod[61:30];
	assign cos_half = cos_prod[62:31];

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s14.neg <= chain[HORNER_STEPS].neg;
			trig_s14.s   <= (sin_raw > 32'(Q30_ONE)) ? Q30_ONE : sin_raw[Q_FRAC:0];
			trig_s14.c   <= (cos_half >= 32'(Q30_ONE)) ? '0 :
				(Q30_ONE - cos_half[Q_FRAC:0]);
		end
	end

	assign trig = trig_s14;

endmodule
`default_nettype wire

// ===== rtl/e2q_combine.sv =====
`default_nettype none
module e2q_combine #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  e2q_pkg::half_trig_t           roll,
	input  e2q_pkg::half_trig_t           pitch,
	input  e2q_pkg::half_trig_t           yaw,
	output logic                          vld_out,
	output logic signed [OUT_FRAC_BITS+1:0] quat_w,
	output logic signed [OUT_FRAC_BITS+1:0] quat_x,
	output logic signed [OUT_FRAC_BITS+1:0] quat_y,
	output logic signed [OUT_FRAC_BITS+1:0] quat_z
);
	import e2q_pkg::*;

	localparam int          OUT_W = OUT_FRAC_BITS + 2;
	localparam int          SH    = Q_FRAC - OUT_FRAC_BITS;
	localparam logic [32:0] HALF  = (33'd1 << SH) >> 1;
	localparam int          LIM   = 1 << OUT_FRAC_BITS;

	function automatic mag_t q30_mul(input mag_t a, input mag_t b);
		logic [61:0] p;
		p = 62'(a) * 62'(b);
		return p[60:30];
	endfunction

	function automatic logic [32:0] signed_mag(input mag_t m, input logic neg);
		logic [32:0] v;
		v = 33'(m);
		return neg ? (~v + 33'd1) : v;
	endfunction

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	mag_t       cc_s1, ss_s1, sc_s1, cs_s1;
	half_trig_t yaw_s1;
	logic       nr_s1, np_s1;

	logic [3:0][Q_FRAC:0] ta_s2, tb_s2;
	logic [3:0]           na_s2, nb_s2;

	logic [3:0][32:0]      sum_s3;
	logic [3:0]            neg_s4;
	logic [3:0][OUT_W-1:0] rnd_s4;
	logic [3:0][OUT_W-1:0] q_s5;

	logic [3:0][OUT_W-1:0] rnd_d;
	logic [3:0][OUT_W-1:0] q_d;
	logic [3:0][OUT_W-1:0] clip;
	logic [3:0][32:0]      mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Roll times pitch, the four pairings that the triple products share.
	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1  <= q30_mul(roll.c, pitch.c);
			ss_s1  <= q30_mul(roll.s, pitch.s);
			sc_s1  <= q30_mul(roll.s, pitch.c);
			cs_s1  <= q30_mul(roll.c, pitch.s);
			yaw_s1 <= yaw;
			nr_s1  <= roll.neg;
			np_s1  <= pitch.neg;
		end
	end

	// Times yaw. Term a is added, term b is added or subtracted; a subtraction
	// is folded into the sign of term b. Order of lanes: w, x, y, z.
	always_ff @(posedge clk) begin
		if (en) begin
			ta_s2[0] <= q30_mul(cc_s1, yaw_s1.c);
			tb_s2[0] <= q30_mul(ss_s1, yaw_s1.s);
			na_s2[0] <= 1'b0;
			nb_s2[0] <= nr_s1 ^ np_s1 ^ yaw_s1.neg;
			ta_s2[1] <= q30_mul(sc_s1, yaw_s1.c);
			tb_s2[1] <= q30_mul(cs_s1, yaw_s1.s);
			na_s2[1] <= nr_s1;
			nb_s2[1] <= ~(np_s1 ^ yaw_s1.neg);
			ta_s2[2] <= q30_mul(cs_s1, yaw_s1.c);
			tb_s2[2] <= q30_mul(sc_s1, yaw_s1.s);
			na_s2[2] <= np_s1;
			nb_s2[2] <= nr_s1 ^ yaw_s1.neg;
			ta_s2[3] <= q30_mul(cc_s1, yaw_s1.s);
			tb_s2[3] <= q30_mul(ss_s1, yaw_s1.c);
			na_s2[3] <= yaw_s1.neg;
			nb_s2[3] <= ~(nr_s1 ^ np_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sum_s3[i] <= signed_mag(ta_s2[i], na_s2[i]) + signed_mag(tb_s2[i], nb_s2[i]);
			end
		end
	end

	// Round the magnitude to nearest, ties away from zero; then clamp to one
	// and restore the sign.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag[i]   = sum_s3[i][32] ? (~sum_s3[i] + 33'd1) : sum_s3[i];
			rnd_d[i] = OUT_W'((mag[i] + HALF) >> SH);
			clip[i]  = (rnd_s4[i] > OUT_W'(LIM)) ? OUT_W'(LIM) : rnd_s4[i];
			q_d[i]   = neg_s4[i] ? (~clip[i] + OUT_W'(1)) : clip[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				neg_s4[i] <= sum_s3[i][32];
				rnd_s4[i] <= rnd_d[i];
				q_s5[i]   <= q_d[i];
			end
		end
	end

	assign vld_out = vld_s5;
	assign quat_w  = q_s5[0];
	assign quat_x  = q_s5[1];
	assign quat_y  = q_s5[2];
	assign quat_z  = q_s5[3];

	for (genvar g = 0; g < 4; g++) begin : g_chk
		a_saturated: assert property (@(posedge clk) disable iff (!arst_n)
			vld_s5 |-> ($signed(q_s5[g]) <= LIM && $signed(q_s5[g]) >= -LIM))
			else $error("quaternion component beyond plus or minus one");
	end

endmodule
`default_nettype wire

// ===== rtl/euler_to_quaternion.sv =====
// Each accepted transaction passes the sine/cosine units, the combine stages and the output
// register. Throughput: one transaction per clock while the spare output entry is free; the
// sine and cosine series are fully pipelined, so every multiplier and reciprocal divider
// takes a new operand each cycle. Reset: arst_n clears all valid bits and the output buffer
// at once; data registers are not reset. No state is kept between transactions.
`default_nettype none
module euler_to_quaternion #(
	parameter int ANGLE_BITS    = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	e2q_angle_if.sink   angles,
	e2q_quat_if.source  quat
);
	import e2q_pkg::*;

	localparam int OUT_W = OUT_FRAC_BITS + 2;

	// The whole pipeline moves on one enable. It stops only when the spare
	// entry of the output buffer is occupied, which is a registered condition,
	// so ready on the input does not depend combinationally on the output side.
	logic adv;
	logic arrive;
	logic take;

	logic [TRIG_LAT-1:0] trig_vld_q;
	half_trig_t          roll_trig, pitch_trig, yaw_trig;

	logic                    comb_vld;
	logic [3:0][OUT_W-1:0]   pipe_q;

	logic                    out_vld_q;
	logic                    skid_vld_q;
	logic [3:0][OUT_W-1:0]   out_data_q;
	logic [3:0][OUT_W-1:0]   skid_data_q;

	assign adv          = !skid_vld_q;
	assign angles.ready = adv;

	// Valid bits that ride alongside the three half-angle sine/cosine units.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_vld_q <= '0;
		end else if (adv) begin
			trig_vld_q <= {trig_vld_q[TRIG_LAT-2:0], angles.valid};
		end
	end

	// Each angle gets its own sine and cosine of the half angle: a phase
	// stage, a scaling multiply, a square, five Horner steps of two stages each
	// and a closing product with clamps.
	e2q_trig #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
		.clk  (clk),
		.en   (adv),
		.angle(angles.roll_angle),
		.trig (roll_trig)
	);

	e2q_trig #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
		.clk  (clk),
		.en   (adv),
		.angle(angles.pitch_angle),
		.trig (pitch_trig)
	);

	e2q_trig #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
		.clk  (clk),
		.en   (adv),
		.angle(angles.yaw_angle),
		.trig (yaw_trig)
	);

	// Triple products, signed sums, rounding and saturation.
	e2q_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_combine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_in (trig_vld_q[TRIG_LAT-1]),
		.roll   (roll_trig),
		.pitch  (pitch_trig),
		.yaw    (yaw_trig),
		.vld_out(comb_vld),
		.quat_w (pipe_q[0]),
		.quat_x (pipe_q[1]),
		.quat_y (pipe_q[2]),
		.quat_z (pipe_q[3])
	);

	// Output buffer: an output register plus one spare entry. When the sink
	// stalls, the result that leaves the pipeline in that same cycle lands in
	// the spare entry, and the pipeline stops the cycle after.
	assign arrive = adv && comb_vld;
	assign take   = out_vld_q && quat.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (!out_vld_q || take) begin
				if (skid_vld_q) begin
					out_vld_q  <= 1'b1;
					skid_vld_q <= 1'b0;
				end else begin
					out_vld_q <= arrive;
				end
			end else if (arrive) begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			out_data_q <= skid_vld_q ? skid_data_q : pipe_q;
		end else if (arrive) begin
			skid_data_q <= pipe_q;
		end
	end

	assign quat.valid  = out_vld_q;
	assign quat.quat_w = out_data_q[0];
	assign quat.quat_x = out_data_q[1];
	assign quat.quat_y = out_data_q[2];
	assign quat.quat_z = out_data_q[3];

	// The spare entry is only ever filled behind a held output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("spare entry holds a result while the output register is empty");

	// A result leaving the pipeline while the output is held must be caught.
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(arrive && out_vld_q && !take) |=> skid_vld_q)
		else $error("result dropped at the output buffer");

	// With the spare entry in use the pipeline must not move.
	a_pipe_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> $stable(comb_vld) && $stable(trig_vld_q))
		else $error("pipeline advanced while the output buffer was full");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Testbench for euler_to_quaternion.
//
// Each transaction on the angle channel carries roll, pitch and yaw angles. The
// testbench predicts the quaternion for each accepted transaction with its own
// bit-exact fixed-point model. The model evaluates the half-angle sine and
// cosine by Taylor series, forms the triple products, then rounds and
// saturates the result. Each prediction waits in a queue until the quaternion
// channel delivers a result, which is then compared field by field.
//
// The stimulus starts with a few directed angle sets: zero, the extremes of
// the binary angle and quarter turns. Random traffic follows. Both sides of
// the block idle at random between transactions, and some stretches of the
// run have no idling at all, so the full one-per-clock rate is also covered.
module testbench;

	localparam int ANGLE_W     = 16;
	localparam int QUAT_W      = 16;
	localparam int FRAC_OUT    = 14;
	localparam int PIPE_DEPTH  = 19;
	localparam int MAX_IDLE    = 19;
	localparam int RANDOM_SETS = 1500;
	localparam int DRAIN_LIMIT = 20000;
	localparam int REPORT_MAX  = 10;

	// Q30 arithmetic constants for the half-angle series.
	localparam longint unsigned ONE_Q30    = 64'd1 << 30;
	localparam longint unsigned PI_SCALED  = 64'd3373259426;
	localparam int              SERIES_LEN = 5;
	localparam longint unsigned SINE_DIVS [SERIES_LEN]   = '{110, 72, 42, 20, 6};
	localparam longint unsigned COSINE_DIVS [SERIES_LEN] = '{132, 90, 56, 30, 12};

	// Angles that tend to expose edge behavior: -pi, just below pi, zero,
	// quarter turns, the smallest steps on either side of zero and the step above -pi.
	localparam logic [ANGLE_W-1:0] ANGLE_CORNERS [8] = '{
		16'h8000, 16'h7FFF, 16'h0000, 16'h4000,
		16'hC000, 16'h0001, 16'hFFFF, 16'h8001
	};

	// Sine magnitude, cosine and sign of one half angle, all in Q30.
	typedef struct {
		logic            neg;
		longint unsigned sin_mag;
		longint unsigned cos_val;
	} half_trig_q30_t;

	typedef struct packed {
		logic signed [QUAT_W-1:0] w;
		logic signed [QUAT_W-1:0] x;
		logic signed [QUAT_W-1:0] y;
		logic signed [QUAT_W-1:0] z;
	} quat_t;

	logic clk;
	logic arst_n;

	e2q_angle_if #(.ANGLE_BITS(ANGLE_W)) angles_bus ();
	e2q_quat_if  #(.OUT_W(QUAT_W))       quat_bus ();

	euler_to_quaternion dut (
		.clk    (clk),
		.arst_n (arst_n),
		.angles (angles_bus),
		.quat   (quat_bus)
	);

	// Quaternions predicted for accepted angle transactions, oldest first.
	quat_t expected_quats [$];

	int fail_count;
	int report_count;

	// Upper bounds of the random idle gaps. A bound of zero turns idling off on
	// that side, which gives back-to-back transactions.
	int angle_gap_max;
	int quat_stall_max;

	// ------------------------------------------------------------------
	// Quaternion predictor.
	// ------------------------------------------------------------------

	// One Horner step of the Taylor series: t = 1 - (x^2 * t) / k.
	function automatic longint unsigned horner_q30(longint unsigned sq,
		longint unsigned acc, longint unsigned div);
		return ONE_Q30 - ((sq * acc) >> 30) / div;
	endfunction

	// Sine and cosine of half the binary angle. The angle is aligned to a
	// 32-bit phase, so that -pi maps to a half angle of exactly -pi/2.
	function automatic half_trig_q30_t half_angle_trig(logic [ANGLE_W-1:0] ang);
		half_trig_q30_t  hs;
		longint unsigned phase;
		longint unsigned mag;
		longint unsigned xm;
		longint unsigned x2;
		longint unsigned acc;
		longint unsigned half_sq;

		phase  = {32'd0, ang, 16'd0};
		hs.neg = ang[ANGLE_W-1];
		mag    = hs.neg ? ((64'd1 << 32) - phase) : phase;
		xm     = (mag * PI_SCALED + (64'd1 << 31)) >> 32;
		x2     = (xm * xm + (64'd1 << 29)) >> 30;

		acc = ONE_Q30;
		for (int i = 0; i < SERIES_LEN; i++)
			acc = horner_q30(x2, acc, SINE_DIVS[i]);
		hs.sin_mag = (xm * acc) >> 30;
		if (hs.sin_mag > ONE_Q30)
			hs.sin_mag = ONE_Q30;

		acc = ONE_Q30;
		for (int i = 0; i < SERIES_LEN; i++)
			acc = horner_q30(x2, acc, COSINE_DIVS[i]);
		half_sq    = ((x2 * acc) >> 30) / 2;
		hs.cos_val = (half_sq >= ONE_Q30) ? 64'd0 : (ONE_Q30 - half_sq);
		return hs;
	endfunction

	// Product of three Q30 magnitudes, truncated after each multiply, then signed.
	function automatic longint signed_product3(longint unsigned a, longint unsigned b,
		longint unsigned c, logic neg);
		longint unsigned m;

		m = (((a * b) >> 30) * c) >> 30;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	// Rounds a Q30 sum to the output format, ties away from zero, and saturates
	// the magnitude at one.
	function automatic logic [QUAT_W-1:0] round_to_output(longint sum);
		logic            neg;
		longint unsigned m;
		longint unsigned r;
		longint unsigned lim;
		longint unsigned val;

		neg = sum < 0;
		m   = neg ? longint'(-sum) : longint'(sum);
		lim = 64'd1 << FRAC_OUT;
		r   = (m + (64'd1 << (29 - FRAC_OUT))) >> (30 - FRAC_OUT);
		if (r > lim)
			r = lim;
		val = neg ? (64'd0 - r) : r;
		return val[QUAT_W-1:0];
	endfunction

	// ZYX conversion from roll, pitch and yaw to (w, x, y, z).
	function automatic quat_t predict_quat(logic [ANGLE_W-1:0] roll,
		logic [ANGLE_W-1:0] pitch, logic [ANGLE_W-1:0] yaw);
		half_trig_q30_t r;
		half_trig_q30_t p;
		half_trig_q30_t y;
		quat_t          q;
		longint         sw;
		longint         sx;
		longint         sy;
		longint         sz;

		r = half_angle_trig(roll);
		p = half_angle_trig(pitch);
		y = half_angle_trig(yaw);

		sw = signed_product3(r.cos_val, p.cos_val, y.cos_val, 1'b0)
			+ signed_product3(r.sin_mag, p.sin_mag, y.sin_mag, r.neg ^ p.neg ^ y.neg);
		sx = signed_product3(r.sin_mag, p.cos_val, y.cos_val, r.neg)
			- signed_product3(r.cos_val, p.sin_mag, y.sin_mag, p.neg ^ y.neg);
		sy = signed_product3(r.cos_val, p.sin_mag, y.cos_val, p.neg)
			+ signed_product3(r.sin_mag, p.cos_val, y.sin_mag, r.neg ^ y.neg);
		sz = signed_product3(r.cos_val, p.cos_val, y.sin_mag, y.neg)
			- signed_product3(r.sin_mag, p.sin_mag, y.cos_val, r.neg ^ p.neg);

		q.w = round_to_output(sw);
		q.x = round_to_output(sx);
		q.y = round_to_output(sy);
		q.z = round_to_output(sz);
		return q;
	endfunction

	// ------------------------------------------------------------------
	// Clock, limit and the two channel processes.
	// ------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop for a hung handshake; far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Sends one angle transaction. The task is entered just after a rising
	// edge; it idles for a random number of cycles and then holds valid until
	// the block takes the transaction. Valid is left high on return, so a
	// following transaction with no gap goes out on the very next cycle.
	task automatic send_angles(logic [ANGLE_W-1:0] roll, logic [ANGLE_W-1:0] pitch,
		logic [ANGLE_W-1:0] yaw);
		int gap;

		gap = (angle_gap_max == 0) ? 0 : $urandom_range(0, angle_gap_max);
		@(negedge clk);
		if (gap != 0) begin
			angles_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		angles_bus.valid       <= 1'b1;
		angles_bus.roll_angle  <= roll;
		angles_bus.pitch_angle <= pitch;
		angles_bus.yaw_angle   <= yaw;
		do
			@(posedge clk);
		while (!angles_bus.ready);
		expected_quats.push_back(predict_quat(roll, pitch, yaw));
	endtask

	// Result side: before each result the receiver stalls for a random number
	// of cycles, then holds ready high until a result is taken.
	initial begin
		int stall;

		quat_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = (quat_stall_max == 0) ? 0 : $urandom_range(0, quat_stall_max);
			@(negedge clk);
			if (stall != 0) begin
				quat_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			quat_bus.ready <= 1'b1;
			do
				@(posedge clk);
			while (!quat_bus.valid);
		end
	end

	// Compares every accepted result with the oldest prediction.
	always @(posedge clk) begin
		quat_t got;
		quat_t want;

		if (arst_n && quat_bus.valid && quat_bus.ready) begin
			got = {quat_bus.quat_w, quat_bus.quat_x, quat_bus.quat_y, quat_bus.quat_z};
			if (expected_quats.size() == 0) begin
				fail_count++;
				if (report_count < REPORT_MAX)
					$display("%0t: unexpected quaternion w=%0d x=%0d y=%0d z=%0d",
						$realtime, got.w, got.x, got.y, got.z);
				report_count++;
			end else begin
				want = expected_quats.pop_front();
				if (got !== want) begin
					fail_count++;
					if (report_count < REPORT_MAX)
						$display("%0t: quaternion mismatch, expected w=%0d x=%0d y=%0d z=%0d, got w=%0d x=%0d y=%0d z=%0d",
							$realtime, want.w, want.x, want.y, want.z,
							got.w, got.x, got.y, got.z);
					report_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Random angle, weighted toward the corners and their neighborhoods.
	function automatic logic [ANGLE_W-1:0] rand_angle();
		logic [31:0] r;

		r = $urandom();
		case ($urandom_range(0, 9))
			0: return ANGLE_CORNERS[$urandom_range(0, 7)];
			1: return ANGLE_CORNERS[$urandom_range(0, 7)] + ANGLE_W'($urandom_range(0, 8))
				- ANGLE_W'(4);
			default: return r[ANGLE_W-1:0];
		endcase
	endfunction

	// Zero rotation and the extremes of the binary angle on each axis. The most
	// negative angle is -pi, where the half-angle sine is exactly -1 and the
	// cosine exactly 0.
	task automatic test_zero_and_extremes();
		send_angles(16'h0000, 16'h0000, 16'h0000);
		send_angles(16'h8000, 16'h0000, 16'h0000);
		send_angles(16'h0000, 16'h8000, 16'h0000);
		send_angles(16'h0000, 16'h0000, 16'h8000);
		send_angles(16'h7FFF, 16'h0000, 16'h0000);
		send_angles(16'h0000, 16'h7FFF, 16'h0000);
		send_angles(16'h0000, 16'h0000, 16'h7FFF);
		send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_angles(16'h8000, 16'h8000, 16'h8000);
		send_angles(16'h8000, 16'h7FFF, 16'h8000);
	endtask

	// Quarter turns, tiny angles and mixed signs. Sums of two products close to
	// one probe the rounding and the saturation at plus or minus one.
	task automatic test_quarter_turns();
		send_angles(16'h4000, 16'h0000, 16'h0000);
		send_angles(16'h0000, 16'h4000, 16'h0000);
		send_angles(16'h0000, 16'h0000, 16'h4000);
		send_angles(16'h4000, 16'h4000, 16'h4000);
		send_angles(16'hC000, 16'hC000, 16'hC000);
		send_angles(16'h0001, 16'hFFFF, 16'h0001);
		send_angles(16'hFFFF, 16'h0001, 16'hFFFF);
		send_angles(16'h2000, 16'hE000, 16'h6000);
		send_angles(16'h8000, 16'h4000, 16'hC000);
	endtask

	// Random angles, with idling on both sides, on one side only and on
	// neither side, so that gaps land on every stage of the pipeline.
	task automatic test_random_traffic();
		for (int i = 0; i < RANDOM_SETS; i++) begin
			case (i % 500)
				0: begin
					angle_gap_max  = MAX_IDLE;
					quat_stall_max = MAX_IDLE;
				end
				200: begin
					angle_gap_max  = 0;
					quat_stall_max = 0;
				end
				300: begin
					angle_gap_max  = MAX_IDLE;
					quat_stall_max = 0;
				end
				400: begin
					angle_gap_max  = 0;
					quat_stall_max = MAX_IDLE;
				end
				default: ;
			endcase
			send_angles(rand_angle(), rand_angle(), rand_angle());
		end
	endtask

	initial begin
		int drain_cycles;

		fail_count             = 0;
		report_count           = 0;
		angle_gap_max          = MAX_IDLE;
		quat_stall_max         = MAX_IDLE;
		arst_n                 = 1'b0;
		angles_bus.valid       = 1'b0;
		angles_bus.roll_angle  = '0;
		angles_bus.pitch_angle = '0;
		angles_bus.yaw_angle   = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_and_extremes();
		test_quarter_turns();
		test_random_traffic();

		@(negedge clk);
		angles_bus.valid <= 1'b0;

		// Let the pipeline drain, then watch a little longer for stray results.
		drain_cycles = 0;
		while (expected_quats.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_cycles++;
		end
		repeat (2 * PIPE_DEPTH) @(posedge clk);

		if (expected_quats.size() != 0) begin
			$display("%0d predicted quaternions never arrived", expected_quats.size());
			fail_count += expected_quats.size();
		end

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== euler_to_quaternion.f =====
rtl/e2q_pkg.sv
rtl/e2q_if.sv
rtl/e2q_horner_stage.sv
rtl/e2q_trig.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
test/testbench.sv
